[rtl/servo_frame_parser_crc16_unit_macros.svh]
// Assertion macros shared by the servo frame parser RTL.
`ifndef SERVO_FRAME_PARSER_CRC16_UNIT_MACROS_SVH
`define SERVO_FRAME_PARSER_CRC16_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define SFP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define SFP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sfp_pkg.sv]
// Types, constants and CRC helper functions for the servo frame parser.
package sfp_pkg;

    localparam int PAYLOAD_BYTES_DEF = 8;
    localparam int NUM_CHANNELS_DEF  = 4;
    localparam int OUT_CHANNELS      = 4;

    localparam logic [7:0] SYNC_FIRST  = 8'hFF;
    localparam logic [7:0] SYNC_SECOND = 8'hFE;

    localparam int REG_IDX_W = 4;
    localparam logic [REG_IDX_W-1:0] REG_POLY    = 4'd0;
    localparam logic [REG_IDX_W-1:0] REG_INIT    = 4'd1;
    localparam logic [REG_IDX_W-1:0] REG_XOROUT  = 4'd2;
    localparam logic [REG_IDX_W-1:0] REG_REFLECT = 4'd3;

    localparam logic [15:0] CRC_POLY_RST    = 16'h8005;
    localparam logic [15:0] CRC_INIT_RST    = 16'h0000;
    localparam logic [15:0] CRC_XOROUT_RST  = 16'h0000;
    localparam logic        CRC_REFLECT_RST = 1'b1;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_SYNC2   = 2'd1,
        PH_COLLECT = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_GOOD = 2'd1,
        EV_BAD  = 2'd2
    } t_event;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       clear_errors;
        logic       ack_new;
    } t_in_item;

    typedef struct packed {
        logic [15:0] chan_rudder;
        logic [15:0] chan_throttle;
        logic [15:0] chan_elevator;
        logic [15:0] chan_aileron;
        logic        new_frame;
        logic [15:0] error_count;
        logic [1:0]  frame_event;
    } t_out_item;

    typedef struct packed {
        logic [REG_IDX_W-1:0] reg_index;
        logic [15:0]          wdata;
    } t_cfg_write;

    typedef struct packed {
        logic [15:0] poly;
        logic [15:0] init;
        logic [15:0] xorout;
        logic        reflect;
    } t_crc_cfg;

    function automatic logic [7:0] rev8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7-i] = b[i];
        end
        return r;
    endfunction

    function automatic logic [15:0] rev16(input logic [15:0] v);
        return {rev8(v[7:0]), rev8(v[15:8])};
    endfunction

    // Byte-wide CRC step, MSB first, eight dependent shift/XOR stages.
    function automatic logic [15:0] crc_byte_update(input logic [15:0] crc,
                                                    input logic [7:0]  b,
                                                    input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ poly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[rtl/sfp_stream_if.sv]
// Valid/ready channel interface carrying one payload item per transaction.
interface sfp_stream_if import sfp_pkg::*; #(
    parameter type T = t_in_item
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/sfp_frame.sv]
// Sync hunt, payload collection, CRC check and channel/status state.
`include "servo_frame_parser_crc16_unit_macros.svh"

module sfp_frame import sfp_pkg::*; #(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
    parameter int NUM_CHANNELS  = NUM_CHANNELS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_crc_cfg  i_cfg,
    output t_out_item o_result
);

    localparam int CW = $clog2(PAYLOAD_BYTES + 2);
    localparam int SW = PAYLOAD_BYTES + 1;
    localparam logic [CW-1:0] CNT_CRC_HI = CW'(PAYLOAD_BYTES);

    t_phase        r_phase, n_phase;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [15:0]   r_crc, n_crc;
    logic [7:0]    r_shift [SW];
    logic [15:0]   r_chan [NUM_CHANNELS];
    logic [15:0]   n_chan [NUM_CHANNELS];
    logic          r_new, n_new;
    logic [15:0]   r_err, n_err;
    logic [15:0]   err_base;
    logic [15:0]   out_chan [OUT_CHANNELS];
    logic          shift_en;
    logic          crc_match;
    t_event        ev;

    assign crc_match = ({r_shift[0], i_item.rx_byte} ==
                        ((i_cfg.reflect ? rev16(r_crc) : r_crc) ^ i_cfg.xorout));

    // Next-state logic of the frame sequencer.
    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_crc    = r_crc;
        shift_en = 1'b0;
        ev       = EV_NONE;
        unique case (r_phase)
            PH_SYNC2: begin
                if (i_item.rx_byte == SYNC_SECOND) begin
                    n_phase = PH_COLLECT;
                    n_cnt   = '0;
                    n_crc   = i_cfg.init;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_COLLECT: begin
                if (r_cnt < CNT_CRC_HI) begin
                    shift_en = 1'b1;
                    n_crc    = crc_byte_update(r_crc,
                                   i_cfg.reflect ? rev8(i_item.rx_byte) : i_item.rx_byte,
                                   i_cfg.poly);
                    n_cnt    = r_cnt + 1'b1;
                end else if (r_cnt == CNT_CRC_HI) begin
                    shift_en = 1'b1;
                    n_cnt    = r_cnt + 1'b1;
                end else begin
                    ev      = crc_match ? EV_GOOD : EV_BAD;
                    n_phase = PH_HUNT;
                    n_cnt   = '0;
                end
            end
            default: begin
                n_phase = (i_item.rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
                n_cnt   = '0;
            end
        endcase
    end

    // The newest byte enters at index 0, so payload byte j sits at index SW-1-j
    // once the high CRC byte has been taken.
    genvar gk;
    generate
        for (gk = 0; gk < NUM_CHANNELS; gk++) begin : g_chan
            if (2 * gk + 1 < PAYLOAD_BYTES) begin : g_load
                assign n_chan[gk] = (ev == EV_GOOD) ?
                                    {r_shift[SW-1-2*gk], r_shift[SW-2-2*gk]} : r_chan[gk];
            end else begin : g_keep
                assign n_chan[gk] = r_chan[gk];
            end
        end
        for (gk = 0; gk < OUT_CHANNELS; gk++) begin : g_out
            if (gk < NUM_CHANNELS) begin : g_used
                assign out_chan[gk] = n_chan[gk];
            end else begin : g_zero
                assign out_chan[gk] = '0;
            end
        end
    endgenerate

    // Status outputs of the sequencer.
    always_comb begin
        n_new    = (i_item.ack_new ? 1'b0 : r_new) | (ev == EV_GOOD);
        err_base = i_item.clear_errors ? '0 : r_err;
        n_err    = err_base;
        if (ev == EV_BAD && err_base != '1) begin
            n_err = err_base + 1'b1;
        end
        o_result.chan_rudder   = out_chan[0];
        o_result.chan_throttle = out_chan[1];
        o_result.chan_elevator = out_chan[2];
        o_result.chan_aileron  = out_chan[3];
        o_result.new_frame     = n_new;
        o_result.error_count   = n_err;
        o_result.frame_event   = ev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_cnt   <= '0;
            r_crc   <= CRC_INIT_RST;
            r_new   <= 1'b0;
            r_err   <= '0;
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_chan[k] <= 16'(k);
            end
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_crc   <= n_crc;
            r_new   <= n_new;
            r_err   <= n_err;
            r_chan  <= n_chan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && shift_en) begin
            r_shift[0] <= i_item.rx_byte;
            for (int i = 1; i < SW; i++) begin
                r_shift[i] <= r_shift[i-1];
            end
        end
    end

    `SFP_ASSERT_NXT(a_bad_counts, i_step && ev == EV_BAD, r_err != '0, "CRC error not counted")
    `SFP_ASSERT_NXT(a_good_flags, i_step && ev == EV_GOOD, r_new, "good frame did not set flag")
    `SFP_ASSERT_IMP(a_cnt_range, r_phase == PH_COLLECT, r_cnt <= CNT_CRC_HI + 1'b1,
                    "byte count ran past the frame")

endmodule

[rtl/servo_frame_parser_crc16_unit.sv]
// An accepted byte passes through the input register and then the result register.
// Throughput: one byte per cycle while results are taken; the byte-wide CRC update and state step fit in one stage.
// A result not yet taken lets the input register take one more byte, then holds the input off.
// Reset (synchronous, active low) sets hunting state, zero flags and error count, channel i = i,
// and CRC registers to the CRC-16/ARC variant. The configuration channel is always ready.
`include "servo_frame_parser_crc16_unit_macros.svh"

module servo_frame_parser_crc16_unit import sfp_pkg::*; #(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
    parameter int NUM_CHANNELS  = NUM_CHANNELS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sfp_stream_if.sink   i_in,
    sfp_stream_if.source o_res,
    sfp_stream_if.sink   i_cfg
);

    t_crc_cfg  r_cfg;
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_res_valid;
    t_out_item r_res;
    t_out_item result;
    logic      step;

    assign step        = r_in_valid && (!r_res_valid || o_res.ready);
    assign i_in.ready  = !r_in_valid || step;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_res_valid;
    assign o_res.data  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poly    <= CRC_POLY_RST;
            r_cfg.init    <= CRC_INIT_RST;
            r_cfg.xorout  <= CRC_XOROUT_RST;
            r_cfg.reflect <= CRC_REFLECT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.reg_index)
                REG_POLY:    r_cfg.poly    <= i_cfg.data.wdata;
                REG_INIT:    r_cfg.init    <= i_cfg.data.wdata;
                REG_XOROUT:  r_cfg.xorout  <= i_cfg.data.wdata;
                REG_REFLECT: r_cfg.reflect <= i_cfg.data.wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (step) begin
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
        if (step) begin
            r_res <= result;
        end
    end

    sfp_frame #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .NUM_CHANNELS  (NUM_CHANNELS)
    ) u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    `SFP_ASSERT_NXT(a_step_fills, step, r_res_valid, "processed byte produced no result")
    `SFP_ASSERT_NXT(a_in_holds, r_in_valid && !step, r_in_valid && $stable(r_in),
                    "stalled byte lost from input stage")
    `SFP_ASSERT_NXT(a_cfg_reflect, i_cfg.valid && i_cfg.data.reg_index == REG_REFLECT,
                    r_cfg.reflect == $past(i_cfg.data.wdata[0]), "reflect register not written")

endmodule

[tb/sv/tb_servo_frame_parser_crc16_unit.sv]
// Self-checking testbench for the servo frame parser with configurable CRC-16 check.
module tb_servo_frame_parser_crc16_unit;
    import sfp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 4000000;
    localparam int unsigned BAD_FRAMES  = 2;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 4'd9;

    logic i_clk;
    logic i_rst_n;

    sfp_stream_if #(.T(t_in_item))   in_if  ();
    sfp_stream_if #(.T(t_out_item))  res_if ();
    sfp_stream_if #(.T(t_cfg_write)) cfg_if ();

    servo_frame_parser_crc16_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // Bytes waiting to be offered and parser status words still to come.
    t_in_item  byte_q [$];
    t_out_item status_q [$];

    int          send_idle;
    int          recv_idle;
    int          hold_left;
    int          fail_count;
    int          pushed_items;
    int unsigned cycles;
    bit          rand_flags;

    // Parser model state and its copy of the CRC registers.
    t_crc_cfg    crc_cfg;
    t_phase      pstate;
    int          nbytes;
    logic [7:0]  fbuf [0:PAYLOAD_BYTES_DEF];
    logic [15:0] crc_run;
    logic [15:0] chan [0:NUM_CHANNELS_DEF-1];
    logic        new_flag;
    logic [15:0] err_total;

    always #4 i_clk = ~i_clk;

    // Feeds one byte into the running CRC, MSB first, or LSB first if reflected.
    function automatic logic [15:0] crc_shift_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] d;
        logic       fb;
        for (int i = 0; i < 8; i++) begin
            d[i] = crc_cfg.reflect ? b[7-i] : b[i];
        end
        for (int i = 7; i >= 0; i--) begin
            fb  = crc[15] ^ d[i];
            crc = {crc[14:0], 1'b0};
            if (fb) begin
                crc = crc ^ crc_cfg.poly;
            end
        end
        return crc;
    endfunction

    function automatic logic [15:0] crc_finish(input logic [15:0] crc);
        logic [15:0] r;
        for (int i = 0; i < 16; i++) begin
            r[i] = crc_cfg.reflect ? crc[15-i] : crc[i];
        end
        return r ^ crc_cfg.xorout;
    endfunction

    function automatic t_out_item parse_byte(input t_in_item it);
        t_out_item   r;
        t_event      ev;
        logic [15:0] got;
        ev = EV_NONE;
        if (it.clear_errors) begin
            err_total = '0;
        end
        if (it.ack_new) begin
            new_flag = 1'b0;
        end
        case (pstate)
            PH_SYNC2: begin
                if (it.rx_byte == SYNC_SECOND) begin
                    pstate  = PH_COLLECT;
                    nbytes  = 0;
                    crc_run = crc_cfg.init;
                end else begin
                    pstate = PH_HUNT;
                end
            end
            PH_COLLECT: begin
                if (nbytes < PAYLOAD_BYTES_DEF) begin
                    fbuf[nbytes] = it.rx_byte;
                    crc_run = crc_shift_byte(crc_run, it.rx_byte);
                    nbytes++;
                end else if (nbytes == PAYLOAD_BYTES_DEF) begin
                    fbuf[PAYLOAD_BYTES_DEF] = it.rx_byte;
                    nbytes++;
                end else begin
                    got = {fbuf[PAYLOAD_BYTES_DEF], it.rx_byte};
                    if (got == crc_finish(crc_run)) begin
                        for (int k = 0; k < NUM_CHANNELS_DEF; k++) begin
                            if (2 * k + 1 < PAYLOAD_BYTES_DEF) begin
                                chan[k] = {fbuf[2*k], fbuf[2*k+1]};
                            end
                        end
                        new_flag = 1'b1;
                        ev = EV_GOOD;
                    end else begin
                        if (err_total != 16'hFFFF) begin
                            err_total++;
                        end
                        ev = EV_BAD;
                    end
                    pstate = PH_HUNT;
                    nbytes = 0;
                end
            end
            default: begin
                if (it.rx_byte == SYNC_FIRST) begin
                    pstate = PH_SYNC2;
                end else begin
                    pstate = PH_HUNT;
                end
                nbytes = 0;
            end
        endcase
        r.chan_rudder   = chan[0];
        r.chan_throttle = chan[1];
        r.chan_elevator = chan[2];
        r.chan_aileron  = chan[3];
        r.new_frame     = new_flag;
        r.error_count   = err_total;
        r.frame_event   = ev;
        return r;
    endfunction

    // Byte driver: predicts the status of every accepted byte.
    always @(posedge i_clk) begin : byte_driver
        logic offer;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                status_q.push_back(parse_byte(in_if.data));
            end
            if (!in_if.valid || in_if.ready) begin
                offer = (byte_q.size() != 0) && ($urandom_range(99) >= send_idle);
                in_if.valid <= offer;
                if (offer) begin
                    in_if.data <= byte_q.pop_front();
                end
            end
        end
    end

    task automatic check_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
        end
    endtask

    always @(posedge i_clk) begin : status_monitor
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got = res_if.data;
                if (status_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected status transaction, expected none, got %h",
                             $time, got);
                end else begin
                    want = status_q.pop_front();
                    check_field("chan_rudder", want.chan_rudder, got.chan_rudder);
                    check_field("chan_throttle", want.chan_throttle, got.chan_throttle);
                    check_field("chan_elevator", want.chan_elevator, got.chan_elevator);
                    check_field("chan_aileron", want.chan_aileron, got.chan_aileron);
                    check_field("new_frame", 16'(want.new_frame), 16'(got.new_frame));
                    check_field("error_count", want.error_count, got.error_count);
                    check_field("frame_event", 16'(want.frame_event), 16'(got.frame_event));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("servo_frame_parser_crc16_unit regression: fail");
            $finish;
        end
    end

    task automatic push_item(input logic [7:0] b, input logic clr, input logic ack);
        t_in_item it;
        it.rx_byte      = b;
        it.clear_errors = clr;
        it.ack_new      = ack;
        byte_q.push_back(it);
        pushed_items++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        if (rand_flags) begin
            push_item(b, $urandom_range(31) == 0, $urandom_range(3) == 0);
        end else begin
            push_item(b, 1'b0, 1'b0);
        end
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic queue_frame(input logic [63:0] pl, input bit bad);
        logic [15:0] crc;
        crc = crc_cfg.init;
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        for (int k = 0; k < PAYLOAD_BYTES_DEF; k++) begin
            crc = crc_shift_byte(crc, pl[63-8*k -: 8]);
            push_byte(pl[63-8*k -: 8]);
        end
        crc = crc_finish(crc);
        if (bad) begin
            crc = crc ^ 16'($urandom_range(65535, 1));
        end
        push_byte(crc[15:8]);
        push_byte(crc[7:0]);
    endtask

    // Twelve zero bytes always end any partial frame and leave the parser hunting.
    task automatic flush_frame();
        for (int k = 0; k < 12; k++) begin
            push_item(8'h00, 1'b0, 1'b0);
        end
    endtask

    task automatic wait_idle();
        while (byte_q.size() != 0 || in_if.valid || status_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [15:0] val);
        t_cfg_write w;
        w.reg_index = idx;
        w.wdata     = val;
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= w;
        @(posedge i_clk);
        while (!cfg_if.ready) begin
            @(posedge i_clk);
        end
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_POLY:    crc_cfg.poly    = val;
            REG_INIT:    crc_cfg.init    = val;
            REG_XOROUT:  crc_cfg.xorout  = val;
            REG_REFLECT: crc_cfg.reflect = val[0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic write_crc(input logic [15:0] poly, input logic [15:0] init,
                             input logic [15:0] xorout, input logic [15:0] reflect);
        write_reg(REG_POLY, poly);
        write_reg(REG_INIT, init);
        write_reg(REG_XOROUT, xorout);
        write_reg(REG_REFLECT, reflect);
    endtask

    // Mostly framed traffic with random payloads, plus noise and broken frames.
    task automatic run_random(input int n);
        int          start;
        int          kind;
        int          m;
        logic [63:0] pl;
        start = pushed_items;
        while (pushed_items - start < n) begin
            while (byte_q.size() > 32) begin
                @(negedge i_clk);
            end
            for (int k = 0; k < 8; k++) begin
                pl[8*k +: 8] = pick_byte();
            end
            kind = $urandom_range(19);
            if (kind < 14) begin
                queue_frame(pl, $urandom_range(2) == 0);
            end else if (kind < 16) begin
                push_byte(pick_byte());
            end else if (kind < 18) begin
                push_byte(SYNC_FIRST);
                push_byte(pick_byte());
            end else begin
                m = $urandom_range(6);
                push_byte(SYNC_FIRST);
                push_byte(SYNC_SECOND);
                for (int k = 0; k < m; k++) begin
                    push_byte(pl[8*k +: 8]);
                end
            end
        end
    endtask

    initial begin : sequencer
        logic [15:0] crc;
        logic [7:0]  b;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        res_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        send_idle    = 16;
        recv_idle    = 77;
        hold_left    = 0;
        fail_count   = 0;
        pushed_items = 0;
        cycles       = 0;
        rand_flags   = 1'b0;
        crc_cfg.poly    = CRC_POLY_RST;
        crc_cfg.init    = CRC_INIT_RST;
        crc_cfg.xorout  = CRC_XOROUT_RST;
        crc_cfg.reflect = CRC_REFLECT_RST;
        pstate    = PH_HUNT;
        nbytes    = 0;
        crc_run   = CRC_INIT_RST;
        new_flag  = 1'b0;
        err_total = '0;
        for (int k = 0; k < NUM_CHANNELS_DEF; k++) begin
            chan[k] = 16'(k);
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // A second 0xFF while waiting for 0xFE drops back to hunting, so 0xFE is ignored.
        push_item(SYNC_FIRST, 1'b0, 1'b0);
        push_item(SYNC_FIRST, 1'b0, 1'b0);
        push_item(SYNC_SECOND, 1'b0, 1'b0);
        // Good frame with sync bytes inside the payload; no resync mid-frame.
        queue_frame(64'h00FF_FE80_7F01_FF00, 1'b0);
        // Bad frame that also acknowledges the new frame on its first byte.
        push_item(SYNC_FIRST, 1'b0, 1'b1);
        push_item(SYNC_SECOND, 1'b0, 1'b0);
        crc = crc_cfg.init;
        for (int k = 0; k < 8; k++) begin
            b = (k % 2 == 0) ? 8'h55 : 8'hAA;
            crc = crc_shift_byte(crc, b);
            push_item(b, 1'b0, 1'b0);
        end
        crc = crc_finish(crc) ^ 16'h0001;
        push_item(crc[15:8], 1'b0, 1'b0);
        push_item(crc[7:0], 1'b1, 1'b0);
        push_item(8'h00, 1'b1, 1'b1);
        wait_idle();

        rand_flags = 1'b1;
        run_random(280);
        wait_idle();

        write_crc(16'h1021, 16'hFFFF, 16'h0000, 16'h0000);
        run_random(280);
        wait_idle();

        // Registers change in the middle of a frame: the running CRC keeps its value.
        send_idle = 77;
        recv_idle = 16;
        flush_frame();
        push_item(SYNC_FIRST, 1'b0, 1'b0);
        push_item(SYNC_SECOND, 1'b0, 1'b0);
        for (int k = 0; k < 4; k++) begin
            push_byte(pick_byte());
        end
        wait_idle();
        write_crc(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001);
        crc = crc_run;
        for (int k = 0; k < 4; k++) begin
            b = pick_byte();
            crc = crc_shift_byte(crc, b);
            push_byte(b);
        end
        crc = crc_finish(crc);
        push_byte(crc[15:8]);
        push_byte(crc[7:0]);
        run_random(260);
        wait_idle();

        write_crc(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFE);
        write_reg(REG_UNUSED, 16'h1234);
        write_reg('1, 16'hFFFF);
        run_random(280);
        wait_idle();

        send_idle = 0;
        recv_idle = 0;
        write_crc(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        run_random(150);
        // Long receiver stall while the sender keeps offering bytes.
        hold_left = 250;
        run_random(80);
        wait_idle();
        run_random(150);
        wait_idle();

        // Back-to-back bad frames after the error counter is cleared.
        rand_flags = 1'b0;
        write_crc(CRC_POLY_RST, CRC_INIT_RST, CRC_XOROUT_RST, 16'(CRC_REFLECT_RST));
        flush_frame();
        push_item(8'h00, 1'b1, 1'b0);
        for (int unsigned f = 0; f < BAD_FRAMES; f++) begin
            while (byte_q.size() > 48) begin
                @(negedge i_clk);
            end
            queue_frame({$urandom, $urandom}, 1'b1);
        end
        push_item(8'h00, 1'b1, 1'b1);
        wait_idle();

        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("servo_frame_parser_crc16_unit regression: pass");
        end else begin
            $display("servo_frame_parser_crc16_unit regression: fail");
        end
        $finish;
    end

endmodule
